// File: hw/rtl/hds_pkg.sv
// hds_pkg: shared types, register codes, reset values and helpers for the
// heat-diffusion stencil block. No dependencies.
`default_nettype none

package hds_pkg;

    localparam int HDS_MAX_WIDTH  = 1024;
    localparam int HDS_MAX_HEIGHT = 1024;
    localparam int HDS_TEMP_BITS  = 16;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SIZE_W     = 11;
    localparam int COEF_W     = 16;
    localparam int MIN_SIZE   = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIFFUSION_RATE = 2'd0,
        CFG_COOLING_FACTOR = 2'd1,
        CFG_GRID_HEIGHT    = 2'd2,
        CFG_GRID_WIDTH     = 2'd3
    } t_cfg_reg;

    localparam logic [COEF_W-1:0] RST_DIFFUSION_RATE = 16'd16384;
    localparam logic [COEF_W-1:0] RST_COOLING_FACTOR = 16'hFFFF;
    localparam logic [SIZE_W-1:0] RST_GRID_SIZE      = 11'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_DIFF,
        ST_MUL_A,
        ST_SUM,
        ST_MUL_C,
        ST_EMIT_UP,
        ST_MUL_S,
        ST_EMIT_SELF
    } t_state;

    typedef enum logic [1:0] {
        MUL_ALPHA,
        MUL_COOL_TMP,
        MUL_COOL_CUR
    } t_mul_sel;

    typedef struct packed {
        logic     capture;     // take the input beat, advance position
        logic     fetch;       // latch line reads, write lines back
        logic     diff;        // latch neighbor mean minus center
        logic     tmp_from_v;  // border cell: skip diffusion
        logic     sum;         // latch saturated center plus delta
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     load_up;     // load cell one row above into output
        logic     load_self;   // load own cooled cell into output
    } t_cmd;

    typedef struct packed {
        logic row_gt0;
        logic interior;
        logic last_row;
        logic out_free;
    } t_stat;

    // clamp a programmed grid size into [MIN_SIZE, hi]
    function automatic logic [31:0] f_clamp_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned hi);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'(MIN_SIZE)) begin
            return 32'(MIN_SIZE);
        end else if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hds_ram.sv
// hds_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module hds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/hds_ctrl.sv
// hds_ctrl: sequencer for one cell at a time; issues datapath commands.
// Depends on hds_pkg.
`default_nettype none

module hds_ctrl import hds_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_READ;
            ST_READ:      n_state = ST_FETCH;
            ST_FETCH:     n_state = i_stat.row_gt0 ? ST_DIFF : ST_IDLE;
            ST_DIFF:      n_state = i_stat.interior ? ST_MUL_A : ST_MUL_C;
            ST_MUL_A:     n_state = ST_SUM;
            ST_SUM:       n_state = ST_MUL_C;
            ST_MUL_C:     n_state = ST_EMIT_UP;
            ST_EMIT_UP: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.last_row ? ST_MUL_S : ST_IDLE;
                end
            end
            ST_MUL_S:     n_state = ST_EMIT_SELF;
            ST_EMIT_SELF: if (i_stat.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_READ: begin
                o_cmd = '0;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            ST_DIFF: begin
                o_cmd.diff       = 1'b1;
                o_cmd.tmp_from_v = !i_stat.interior;
            end
            ST_MUL_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ALPHA;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
            end
            ST_MUL_C: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_COOL_TMP;
            end
            ST_EMIT_UP: begin
                o_cmd.load_up = i_stat.out_free;
            end
            ST_MUL_S: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_COOL_CUR;
            end
            ST_EMIT_SELF: begin
                o_cmd.load_self = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/hds_datapath.sv
// hds_datapath: raster position, two line buffers, stencil arithmetic with
// one shared multiplier, and the output register. Depends on hds_pkg, hds_ram.
`default_nettype none

module hds_datapath import hds_pkg::*; #(
    parameter int MAX_WIDTH  = HDS_MAX_WIDTH,
    parameter int MAX_HEIGHT = HDS_MAX_HEIGHT,
    parameter int TEMP_BITS  = HDS_TEMP_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_cmd                              i_cmd,
    output t_stat                                  o_stat,
    input  wire logic signed [TEMP_BITS-1:0]       i_cell_temp,
    input  wire logic                              i_source_present,
    input  wire logic signed [TEMP_BITS-1:0]       i_source_temp,
    input  wire logic [COEF_W-1:0]                 i_alpha,
    input  wire logic [COEF_W-1:0]                 i_cool,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    i_w_eff,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   i_h_eff,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [TEMP_BITS-1:0]                   o_result_temp,
    output logic                                   o_frame_end,
    output logic                                   o_run_end
);

    localparam int TB = TEMP_BITS;
    localparam int CA = $clog2(MAX_WIDTH);
    localparam int RA = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = TB + 18;

    function automatic logic [TB-1:0] f_sat(input logic signed [TB+2:0] x);
        if (x[TB+2:TB-1] == '0 || x[TB+2:TB-1] == '1) begin
            return x[TB-1:0];
        end else if (x[TB+2]) begin
            return {1'b1, {(TB-1){1'b0}}};
        end
        return {1'b0, {(TB-1){1'b1}}};
    endfunction

    // ---------------- raster position ----------------
    logic [CA-1:0] r_col, n_col, c_now;
    logic [RA-1:0] r_row, n_row, r_now;
    logic          col_over;
    logic [HW-1:0] row_tmp, row_inc;
    logic [WW-1:0] col_inc;

    always_comb begin
        // a size change may leave the counters out of range: renormalize
        col_over = WW'(r_col) >= i_w_eff;
        row_tmp  = HW'(r_row) + HW'(col_over);
        c_now    = col_over ? '0 : r_col;
        r_now    = (row_tmp >= i_h_eff) ? '0 : RA'(row_tmp);
        col_inc  = WW'(c_now) + WW'(1);
        row_inc  = HW'(r_now) + HW'(1);
        if (col_inc >= i_w_eff) begin
            n_col = '0;
            n_row = (row_inc >= i_h_eff) ? '0 : RA'(row_inc);
        end else begin
            n_col = CA'(col_inc);
            n_row = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.capture) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- per-cell capture ----------------
    logic [CA-1:0]          r_c;
    logic                   r_row_gt0, r_last_row, r_last_col, r_interior;
    logic signed [TB-1:0]   r_cur, cur_in;

    assign cur_in = (i_source_present && (i_source_temp > i_cell_temp)) ?
                    i_source_temp : i_cell_temp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_c        <= c_now;
            r_cur      <= cur_in;
            r_row_gt0  <= (r_now != '0);
            r_last_row <= (HW'(r_now) == i_h_eff - HW'(1));
            r_last_col <= (WW'(c_now) == i_w_eff - WW'(1));
            r_interior <= (r_now > RA'(1)) && (c_now != '0) &&
                          (WW'(c_now) <= i_w_eff - WW'(2));
        end
    end

    // ---------------- line buffers ----------------
    logic [TB-1:0] up_rdata, mid_rdata;
    logic [CA-1:0] mid_raddr;

    // during fetch, look ahead to the right neighbor
    assign mid_raddr = i_cmd.fetch ? CA'(r_c + CA'(1)) : r_c;

    hds_ram #(.WIDTH(TB), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fetch),
        .i_waddr (r_c),
        .i_wdata (mid_rdata),
        .i_raddr (r_c),
        .o_rdata (up_rdata)
    );

    hds_ram #(.WIDTH(TB), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fetch),
        .i_waddr (r_c),
        .i_wdata (r_cur),
        .i_raddr (mid_raddr),
        .o_rdata (mid_rdata)
    );

    // ---------------- stencil arithmetic ----------------
    logic signed [TB-1:0]   r_up, r_v, r_left, r_tmp;
    logic signed [TB:0]     r_diff, diff, mul_a;
    logic signed [TB+1:0]   nsum, shifted;
    logic signed [TB-1:0]   mean;
    logic signed [COEF_W:0] mul_b;
    logic signed [PW-1:0]   r_prod, prod;
    logic signed [TB+2:0]   acc, cooled;

    always_comb begin
        nsum = (TB+2)'(r_up) + (TB+2)'(r_left) + (TB+2)'($signed(mid_rdata))
             + (TB+2)'(r_cur);
        mean = nsum[TB+1:2];
        diff = (TB+1)'(mean) - (TB+1)'(r_v);
        unique case (i_cmd.mul_sel)
            MUL_ALPHA: begin
                mul_a = r_diff;
                mul_b = $signed({1'b0, i_alpha});
            end
            MUL_COOL_TMP: begin
                mul_a = (TB+1)'(r_tmp);
                mul_b = $signed({1'b0, i_cool});
            end
            MUL_COOL_CUR: begin
                mul_a = (TB+1)'(r_cur);
                mul_b = $signed({1'b0, i_cool});
            end
            default: begin
                mul_a = r_diff;
                mul_b = $signed({1'b0, i_alpha});
            end
        endcase
        prod    = PW'(mul_a) * PW'(mul_b);
        shifted = r_prod[PW-1:16];
        acc     = (TB+3)'(r_v) + (TB+3)'(shifted);
        cooled  = (TB+3)'(shifted);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_left <= r_v;   // previous cell's middle entry, now upper[c-1]
        end
        if (i_cmd.fetch) begin
            r_up <= $signed(up_rdata);
            r_v  <= $signed(mid_rdata);
        end
        if (i_cmd.diff) begin
            r_diff <= diff;
        end
        if (i_cmd.tmp_from_v) begin
            r_tmp <= r_v;
        end else if (i_cmd.sum) begin
            r_tmp <= $signed(f_sat(acc));
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
        end
    end

    // ---------------- output register ----------------
    logic r_ovalid, r_olast, r_ouser;
    logic [TB-1:0] r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_up || i_cmd.load_self) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_up) begin
            r_odata <= f_sat(cooled);
            r_olast <= 1'b0;
            r_ouser <= !r_last_row;
        end else if (i_cmd.load_self) begin
            r_odata <= f_sat(cooled);
            r_olast <= r_last_col;
            r_ouser <= 1'b1;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_result_temp = r_odata;
    assign o_frame_end   = r_olast;
    assign o_run_end     = r_ouser;

    assign o_stat.row_gt0  = r_row_gt0;
    assign o_stat.interior = r_interior;
    assign o_stat.last_row = r_last_row;
    assign o_stat.out_free = !r_ovalid || i_out_ready;

endmodule

`default_nettype wire

// File: hw/rtl/heat_diffusion_stencil_step_top.sv
// heat_diffusion_stencil_step_top: one five-point Jacobi heat-diffusion sweep
// over a raster-order cell stream. Depends on hds_pkg, hds_ctrl, hds_datapath.
//
//  Channel   | Direction | Beat contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tdata: cell_temp, source_temp; tuser: source_present
//  m_axis    | out       | tdata: result_temp; tlast: frame_end; tuser: run_end
//  cfg       | in        | i_cfg_we / i_cfg_addr / i_cfg_wdata, write only
//
// One beat is worked on at a time: first-row cells are only fetched; border
// cells add the diff, cooling and emit of the row above; interior cells the
// alpha step; last-row cells their own cooled result. The steps follow the
// shared multiplier and registered buffer reads; m_axis stalls hold a waiting
// result. Reset (i_rst_n low, synchronous) clears position, sequencer, output
// valid and registers to their defaults, not the line buffers.
`default_nettype none

module heat_diffusion_stencil_step_top import hds_pkg::*; #(
    parameter int MAX_WIDTH  = HDS_MAX_WIDTH,
    parameter int MAX_HEIGHT = HDS_MAX_HEIGHT,
    parameter int TEMP_BITS  = HDS_TEMP_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // slave stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata, low bit up: cell_temp, source_temp, zero fill
    input  wire logic [((2*TEMP_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // tuser: source_present
    input  wire logic                                  s_axis_tuser,
    // master stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata, low bit up: result_temp, zero fill
    output logic [((TEMP_BITS+7)/8)*8-1:0]             m_axis_tdata,
    output logic                                       m_axis_tlast,   // frame_end
    // tuser: run_end
    output logic                                       m_axis_tuser,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]                 i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]                 i_cfg_wdata
);

    localparam int TB    = TEMP_BITS;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int OUT_W = ((TEMP_BITS + 7) / 8) * 8;

    // configuration registers; grid sizes are held already clamped
    logic [COEF_W-1:0] r_alpha, r_cool;
    logic [WW-1:0]     r_w_eff;
    logic [HW-1:0]     r_h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= RST_DIFFUSION_RATE;
            r_cool  <= RST_COOLING_FACTOR;
            r_w_eff <= WW'(f_clamp_size(RST_GRID_SIZE, MAX_WIDTH));
            r_h_eff <= HW'(f_clamp_size(RST_GRID_SIZE, MAX_HEIGHT));
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_DIFFUSION_RATE: r_alpha <= i_cfg_wdata;
                CFG_COOLING_FACTOR: r_cool  <= i_cfg_wdata;
                CFG_GRID_HEIGHT:
                    r_h_eff <= HW'(f_clamp_size(i_cfg_wdata[SIZE_W-1:0], MAX_HEIGHT));
                CFG_GRID_WIDTH:
                    r_w_eff <= WW'(f_clamp_size(i_cfg_wdata[SIZE_W-1:0], MAX_WIDTH));
                default: r_alpha <= r_alpha;
            endcase
        end
    end

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  out_valid;
    logic [TB-1:0] result_temp;
    logic  frame_end, run_end;

    hds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hds_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .TEMP_BITS  (TEMP_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cell_temp      ($signed(s_axis_tdata[TB-1:0])),
        .i_source_present (s_axis_tuser),
        .i_source_temp    ($signed(s_axis_tdata[2*TB-1:TB])),
        .i_alpha          (r_alpha),
        .i_cool           (r_cool),
        .i_w_eff          (r_w_eff),
        .i_h_eff          (r_h_eff),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (out_valid),
        .o_result_temp    (result_temp),
        .o_frame_end      (frame_end),
        .o_run_end        (run_end)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = OUT_W'(result_temp);
    assign m_axis_tlast  = frame_end;
    assign m_axis_tuser  = run_end;

`ifndef SYNTHESIS
    // one cell in flight: the sequencer must leave idle after taking a beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a cell is still in flight");

    // the last cell of a frame is always the closing result of its beat
    a_frame_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("frame end on a result that does not close its beat");

    // held grid sizes stay inside the supported range
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_w_eff >= WW'(MIN_SIZE)) && (r_w_eff <= WW'(MAX_WIDTH)) &&
        (r_h_eff >= HW'(MIN_SIZE)) && (r_h_eff <= HW'(MAX_HEIGHT)))
        else $error("clamped grid size out of range");
`endif

endmodule

`default_nettype wire
